/* design/planar_predictor_decode_core_macros.svh */
// Assertion macros shared by the RTL.
`ifndef PLANAR_PREDICTOR_DECODE_CORE_MACROS_SVH
`define PLANAR_PREDICTOR_DECODE_CORE_MACROS_SVH

// Property holds at every edge outside reset.
`define PPD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/ppd_pkg.sv */
package ppd_pkg;

	localparam int ROW_WIDTH_W = 13;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 13;
	localparam int SAMPLE_W    = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ELT_SIZE  = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		ELT_8  = 2'd0,
		ELT_16 = 2'd1,
		ELT_32 = 2'd2,
		ELT_64 = 2'd3
	} elt_size_t;

	function automatic logic [SAMPLE_W-1:0] elt_mask(input elt_size_t code);
		logic [SAMPLE_W-1:0] m;
		case (code)
			ELT_8:   m = SAMPLE_W'(64'h0000_0000_0000_00FF);
			ELT_16:  m = SAMPLE_W'(64'h0000_0000_0000_FFFF);
			ELT_32:  m = SAMPLE_W'(64'h0000_0000_FFFF_FFFF);
			default: m = '1;
		endcase
		return m;
	endfunction

endpackage

/* design/ppd_if.sv */
interface ppd_in_if;
	logic                          valid;
	logic                          ready;
	logic [ppd_pkg::SAMPLE_W-1:0]  residual;
	logic                          last_of_frame;

	modport source (output valid, output residual, output last_of_frame, input ready);
	modport sink   (input valid, input residual, input last_of_frame, output ready);
endinterface

interface ppd_out_if;
	logic                          valid;
	logic                          ready;
	logic [ppd_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

/* design/ppd_line_buf.sv */
// Previous-row store: one write port, one registered read port.
// A read at the address being written in the same cycle returns the new data.
module ppd_line_buf #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [ppd_pkg::SAMPLE_W-1:0] wr_data,
	output logic [ppd_pkg::SAMPLE_W-1:0] rd_data
);

	logic [ppd_pkg::SAMPLE_W-1:0] mem [DEPTH];
	logic [ppd_pkg::SAMPLE_W-1:0] rd_raw_q;
	logic [ppd_pkg::SAMPLE_W-1:0] byp_data_q;
	logic                         byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_raw_q   <= mem[rd_addr];
			byp_data_q <= wr_data;
			byp_q      <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_raw_q;

endmodule

/* design/planar_predictor_decode_core.sv */
// Channel  Dir  Payload                         Handshake
// in_ch    in   residual[63:0], last_of_frame   valid/ready
// out_ch   out  sample[63:0]                    valid/ready
//
// One item per cycle sustained while out_ch.ready stays high: an accepted item
// reads the line buffer into stage 1, the add/sub chain runs in stage 1, and
// the result lands in the output register, which drives out_ch.valid.
// arst_n clears the column counter, row state, predictors and valids; the
// line buffer holds no reset. A stalled output holds stage 1, and in_ch.ready
// drops only while both stage 1 and the output register are full.
`include "planar_predictor_decode_core_macros.svh"

module planar_predictor_decode_core #(
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ppd_in_if.sink                         in_ch,
	ppd_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [ppd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_ROW_WIDTH);
	localparam int WW = CW + 1;

	// configuration
	logic [ppd_pkg::ROW_WIDTH_W-1:0] row_width_q;
	ppd_pkg::elt_size_t              elt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ppd_pkg::ROW_WIDTH_W'(1);
			elt_q       <= ppd_pkg::ELT_8;
		end else if (cfg_we) begin
			case (cfg_index)
				ppd_pkg::CFG_ROW_WIDTH: row_width_q <= cfg_data[ppd_pkg::ROW_WIDTH_W-1:0];
				ppd_pkg::CFG_ELT_SIZE:  elt_q <= ppd_pkg::elt_size_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// effective row width, clamped to 1..MAX_ROW_WIDTH
	logic [31:0]   rw32;
	logic [31:0]   eff32;
	logic [WW-1:0] eff_w;

	always_comb begin
		rw32 = 32'(row_width_q);
		if (rw32 == 32'd0) begin
			eff32 = 32'd1;
		end else if (rw32 > 32'(MAX_ROW_WIDTH)) begin
			eff32 = 32'(MAX_ROW_WIDTH);
		end else begin
			eff32 = rw32;
		end
		eff_w = eff32[WW-1:0];
	end

	// front: column tracking at accept
	logic [CW-1:0] col_q;
	logic          first_q;
	logic          acc;
	logic          col_wrap;
	logic [CW-1:0] col_cur;
	logic          first_cur;
	logic [WW-1:0] col_inc;
	logic          end_row;

	assign acc       = in_ch.valid && in_ch.ready;
	assign col_wrap  = {1'b0, col_q} >= eff_w;
	assign col_cur   = col_wrap ? '0 : col_q;
	assign first_cur = col_wrap ? 1'b0 : first_q;
	assign col_inc   = {1'b0, col_cur} + WW'(1);
	assign end_row   = col_inc >= eff_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
		end else if (acc) begin
			if (in_ch.last_of_frame) begin
				col_q   <= '0;
				first_q <= 1'b1;
			end else if (end_row) begin
				col_q   <= '0;
				first_q <= 1'b0;
			end else begin
				col_q   <= col_inc[CW-1:0];
				first_q <= first_cur;
			end
		end
	end

	// stage 1
	logic                         v_s1;
	logic [ppd_pkg::SAMPLE_W-1:0] res_s1;
	logic                         last_s1;
	logic [CW-1:0]                col_s1;
	logic                         first_s1;
	logic                         col0_s1;
	logic                         adv;
	logic                         out_v_q;
	logic [ppd_pkg::SAMPLE_W-1:0] out_q;
	logic [ppd_pkg::SAMPLE_W-1:0] left_q;
	logic [ppd_pkg::SAMPLE_W-1:0] abl_q;
	logic [ppd_pkg::SAMPLE_W-1:0] rd_data;
	logic [ppd_pkg::SAMPLE_W-1:0] mask;
	logic [ppd_pkg::SAMPLE_W-1:0] above;
	logic [ppd_pkg::SAMPLE_W-1:0] pred;
	logic [ppd_pkg::SAMPLE_W-1:0] abl_n;
	logic [ppd_pkg::SAMPLE_W-1:0] result;

	assign adv         = v_s1 && (!out_v_q || out_ch.ready);
	assign in_ch.ready = !v_s1 || adv;

	ppd_line_buf #(
		.DEPTH (MAX_ROW_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (col_cur),
		.wr_en   (adv),
		.wr_addr (col_s1),
		.wr_data (result),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1   <= in_ch.residual;
			last_s1  <= in_ch.last_of_frame;
			col_s1   <= col_cur;
			first_s1 <= first_cur;
			col0_s1  <= (col_cur == '0);
		end
	end

	always_comb begin
		mask  = ppd_pkg::elt_mask(elt_q);
		above = rd_data & mask;
		if (first_s1) begin
			pred  = col0_s1 ? '0 : left_q;
			abl_n = '0;
		end else begin
			pred  = col0_s1 ? above : left_q + above - abl_q;
			abl_n = above;
		end
		result = (pred + (res_s1 & mask)) & mask;
	end

	// predictors and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			abl_q   <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			left_q  <= last_s1 ? '0 : result;
			abl_q   <= last_s1 ? '0 : abl_n;
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= result;
		end
	end

	assign out_ch.valid  = out_v_q;
	assign out_ch.sample = out_q;

	`PPD_ASSERT(a_sample_masked, clk, arst_n, !out_v_q || ((out_q & ~mask) == '0), "sample exceeds element width")
	`PPD_ASSERT_NEXT(a_frame_restart, clk, arst_n, acc && in_ch.last_of_frame, first_q && (col_q == '0), "frame end did not return to row zero")
	`PPD_ASSERT(a_ready_only_when_full, clk, arst_n, in_ch.ready || (v_s1 && out_v_q), "input stalled with room in the pipe")
	`PPD_ASSERT_NEXT(a_adv_fills_out, clk, arst_n, adv, out_v_q, "advanced item missing at output")

endmodule

/* test/ppd_recon_checker.sv */
module ppd_recon_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	ppd_in_if                              in_ch,
	ppd_out_if                             out_ch,
	input  logic                           cfg_we,
	input  logic [ppd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import ppd_pkg::*;

	localparam int ROW_LIMIT  = 4096;

	logic [SAMPLE_W-1:0]    prev_row [ROW_LIMIT];
	logic [SAMPLE_W-1:0]    left_val;
	logic [SAMPLE_W-1:0]    above_left_val;
	int unsigned            col;
	bit                     top_row;
	logic [ROW_WIDTH_W-1:0] width_cfg;
	elt_size_t              elt_cfg;
	logic [SAMPLE_W-1:0]    expected_samples [$];

	task automatic reconstruct(input logic [SAMPLE_W-1:0] residual, input logic last);
		logic [SAMPLE_W-1:0] mask;
		logic [SAMPLE_W-1:0] above;
		logic [SAMPLE_W-1:0] pred;
		logic [SAMPLE_W-1:0] value;
		int unsigned         w;
		int                  bits;
		bits = 8 << int'(elt_cfg);
		mask = {SAMPLE_W{1'b1}} >> (SAMPLE_W - bits);
		w = (width_cfg == '0) ? 1 : ((width_cfg > ROW_LIMIT) ? ROW_LIMIT : width_cfg);
		// a row cut short by a narrower width counts as finished
		if (col >= w) begin
			col = 0;
			top_row = 1'b0;
		end
		if (top_row) begin
			pred = (col == 0) ? '0 : left_val;
			above_left_val = '0;
		end else begin
			above = prev_row[col] & mask;
			pred = (col == 0) ? above : left_val + above - above_left_val;
			above_left_val = above;
		end
		value = (pred + (residual & mask)) & mask;
		prev_row[col] = value;
		left_val = value;
		col++;
		if (col >= w) begin
			col = 0;
			top_row = 1'b0;
		end
		if (last) begin
			col = 0;
			top_row = 1'b1;
			left_val = '0;
			above_left_val = '0;
		end
		expected_samples.push_back(value);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [SAMPLE_W-1:0] want;
		if (!arst_n) begin
			col = 0;
			top_row = 1'b1;
			left_val = '0;
			above_left_val = '0;
			width_cfg = ROW_WIDTH_W'(1);
			elt_cfg = ELT_8;
			expected_samples.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ROW_WIDTH)
					width_cfg = cfg_data[ROW_WIDTH_W-1:0];
				else if (cfg_index == CFG_ELT_SIZE)
					elt_cfg = elt_size_t'(cfg_data[1:0]);
			end
			if (in_ch.valid && in_ch.ready)
				reconstruct(in_ch.residual, in_ch.last_of_frame);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: sample expected none, actual %h", $time, out_ch.sample);
					mismatches++;
				end else begin
					want = expected_samples.pop_front();
					if (out_ch.sample !== want) begin
						$display("%0t: sample expected %h, actual %h",
							$time, want, out_ch.sample);
						mismatches++;
					end
				end
			end
			outstanding <= expected_samples.size();
		end
	end

endmodule

/* test/planar_predictor_decode_core_tb.sv */
module planar_predictor_decode_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ppd_pkg::*;

	localparam int RANDOM_ITEMS = 1550;
	localparam int ROW_LIMIT    = 4096;
	localparam int IDLE_PCT     = 21;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;
	bit                    steady;
	int unsigned           cur_width;
	bit                    frame_open;
	int                    random_items;

	ppd_in_if  in_ch();
	ppd_out_if out_ch();

	planar_predictor_decode_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ppd_recon_checker recon_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		#2_000_000;
		$display("** planar_predictor_decode_core: FAILED **");
		$finish;
	end

	task automatic send_item(input logic [SAMPLE_W-1:0] residual, input logic last);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.residual <= residual;
		in_ch.last_of_frame <= last;
		do @(posedge clk); while (!in_ch.ready);
		frame_open = !last;
	endtask

	task automatic drain;
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// write both registers once the pipeline is empty
	task automatic set_mode(input int unsigned raw_width, input elt_size_t elt);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROW_WIDTH;
		cfg_data <= CFG_DATA_W'(raw_width);
		@(posedge clk);
		cfg_index <= CFG_ELT_SIZE;
		cfg_data <= CFG_DATA_W'(elt);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (raw_width == 0)
			cur_width = 1;
		else if (raw_width > ROW_LIMIT)
			cur_width = ROW_LIMIT;
		else
			cur_width = raw_width;
	endtask

	// within an open frame the row may only shrink, so no unwritten column is read
	task automatic random_phase(input bit closing);
		int unsigned raw;
		int          n;
		bit          last;
		if (frame_open) begin
			raw = $urandom_range(cur_width, 1);
			if ($urandom_range(9) == 0)
				raw = 0;
		end else begin
			case ($urandom_range(19))
				0:          raw = 0;
				1, 2, 3, 4: raw = $urandom_range(64, 9);
				5:          raw = $urandom_range(300, 65);
				default:    raw = $urandom_range(8, 1);
			endcase
		end
		set_mode(raw, elt_size_t'($urandom_range(3)));
		n = $urandom_range(80, 10);
		for (int i = 0; i < n; i++) begin
			last = (closing && i == n - 1) || ($urandom_range(39) == 0);
			send_item({$urandom, $urandom}, last);
			random_items++;
		end
	endtask

	// clamp to the longest row, reach its second row, then cut the row short
	task automatic wide_frame;
		int n;
		if (frame_open)
			send_item({$urandom, $urandom}, 1'b1);
		set_mode($urandom_range(8191, ROW_LIMIT + 1), elt_size_t'($urandom_range(3)));
		n = ROW_LIMIT + $urandom_range(40, 8);
		for (int i = 0; i < n; i++)
			send_item({$urandom, $urandom}, 1'b0);
		set_mode(5, elt_size_t'($urandom_range(3)));
		for (int i = 0; i < 20; i++)
			send_item({$urandom, $urandom}, i == 19);
	endtask

	initial begin
		int phase;
		in_ch.valid <= 1'b0;
		in_ch.residual <= '0;
		in_ch.last_of_frame <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ROW_WIDTH;
		cfg_data <= '0;
		steady = 1'b0;
		cur_width = 1;
		frame_open = 1'b0;
		random_items = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one-sample rows of 8-bit elements
		send_item(64'hFFFF_FFFF_FFFF_FF80, 1'b0);
		send_item('0, 1'b0);
		send_item({$urandom, $urandom}, 1'b1);

		// zero width acts as one
		set_mode(0, ELT_64);
		send_item('1, 1'b0);
		send_item(64'h8000_0000_0000_0001, 1'b0);
		send_item('1, 1'b1);

		set_mode(3, ELT_16);
		send_item('1, 1'b0);
		send_item('1, 1'b0);
		send_item('0, 1'b0);
		send_item(64'h0000_0000_0000_8000, 1'b0);
		send_item('1, 1'b0);
		send_item(64'h5555_AAAA_5555_AAAA, 1'b0);
		send_item('0, 1'b0);

		// mid-row: narrower row and wider elements while the frame is open
		set_mode(1, ELT_32);
		send_item(64'hFFFF_FFFF_0000_0001, 1'b0);
		send_item('1, 1'b0);
		send_item({$urandom, $urandom}, 1'b0);
		send_item('0, 1'b1);

		// frame ends mid-row
		set_mode(4, ELT_8);
		send_item({$urandom, $urandom}, 1'b0);
		send_item({$urandom, $urandom}, 1'b1);
		send_item('1, 1'b0);
		send_item({$urandom, $urandom}, 1'b0);
		send_item({$urandom, $urandom}, 1'b0);

		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			steady = (phase >= 6 && phase <= 9);
			if (phase == 12)
				wide_frame();
			random_phase($urandom_range(1));
			phase++;
		end
		steady = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("** planar_predictor_decode_core: PASSED **");
		else
			$display("** planar_predictor_decode_core: FAILED **");
		$finish;
	end

endmodule
